/* hdl/rgbsob_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rgbsob_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(HEIGHT_LIMIT);
  localparam int CMP_W    = 16;
  localparam int SUM_W    = 16;

  localparam logic [PIX_W-1:0] W_BLUE  = 8'b00010010;
  localparam logic [PIX_W-1:0] W_GREEN = 8'b10110111;
  localparam logic [PIX_W-1:0] W_RED   = 8'b00110110;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic produce;
    logic eol;
    logic eof;
  } item_flags_t;

endpackage
`default_nettype wire

/* hdl/rgbsob_pix_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface rgbsob_pix_if;
  logic                   valid;
  logic                   ready;
  logic [rgbsob_pkg::PIX_W-1:0] blue;
  logic [rgbsob_pkg::PIX_W-1:0] green;
  logic [rgbsob_pkg::PIX_W-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface
`default_nettype wire

/* hdl/rgbsob_edge_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface rgbsob_edge_if;
  logic                   valid;
  logic                   ready;
  logic [rgbsob_pkg::PIX_W-1:0] edge_magnitude;
  logic                   end_of_line;
  logic                   end_of_frame;

  modport source (output valid, output edge_magnitude, output end_of_line,
                  output end_of_frame, input ready);
  modport sink   (input valid, input edge_magnitude, input end_of_line,
                  input end_of_frame, output ready);
endinterface
`default_nettype wire

/* hdl/rgb_gray_sobel_edge_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// 3x3 Sobel edge detector on a raster stream of BGR pixels.
// in_chan carries one pixel per transaction, in raster order; each pixel is
// converted to gray and pushed through two line buffers and a 3x3 window.
// out_chan carries one edge magnitude for each pixel whose window lies fully
// inside the frame, i.e. (height-2) x (width-2) results per frame, with
// end_of_line and end_of_frame flags on the last result of a line / frame.
// The APB port sets image_width (0x0) and image_height (0x4); any write to
// either register restarts the frame at row 0, column 0.
// Throughput: one pixel per clock while the receiver keeps up. The edge
// that accepts a pixel also reads the line memory, and the output register
// loads when that pixel leaves the memory read stage. The line memory keeps
// one 16-bit entry per column (line two above, line above) and
// is read and written once per pixel at the current column.
// Reset restores 640 x 480 and column/row zero; no clearing pass is run.
// When the receiver stalls, one result waits in the output register and one
// pixel in the memory read stage; in_chan.ready then drops.
module rgb_gray_sobel_edge_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rgbsob_pix_if.sink                            in_chan,
  rgbsob_edge_if.source                         out_chan,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rgbsob_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rgbsob_pkg::PDATA_W-1:0]   pwdata,
  output logic      [rgbsob_pkg::PDATA_W-1:0]   prdata,
  output logic                                  pready
);

  localparam int PixW = rgbsob_pkg::PIX_W;
  localparam int ColW = rgbsob_pkg::COL_W;
  localparam int RowW = rgbsob_pkg::ROW_W;
  localparam int CmpW = rgbsob_pkg::CMP_W;
  localparam int SumW = rgbsob_pkg::SUM_W;

  // configuration
  logic [rgbsob_pkg::WIDTH_W-1:0]  image_width_r;
  logic [rgbsob_pkg::HEIGHT_W-1:0] image_height_r;
  logic                            cfg_wr;
  rgbsob_pkg::reg_idx_t            cfg_idx;
  logic [CmpW-1:0]                 w_eff;
  logic [CmpW-1:0]                 h_eff;

  // position counters
  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;

  // stage 1: memory read
  logic                    in_acc;
  logic                    s1_valid_r;
  logic                    s1_adv;
  logic [ColW-1:0]         s1_addr_r;
  rgbsob_pkg::pix_t        s1_gray_r;
  rgbsob_pkg::item_flags_t s1_flags_r;
  rgbsob_pkg::item_flags_t s0_flags;
  logic [SumW-1:0]         gray_sum;

  // line memory: {line two above, line above}
  logic [2*PixW-1:0] line_mem [rgbsob_pkg::MAX_WIDTH];
  logic [2*PixW-1:0] rd_data_r;
  rgbsob_pkg::pix_t  top_pix;
  rgbsob_pkg::pix_t  mid_pix;

  rgbsob_pkg::pix_t win_r [6];

  // sobel
  logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
  logic [10:0] mag;
  rgbsob_pkg::pix_t mag_sat;

  // output register
  logic             out_valid_r;
  rgbsob_pkg::pix_t out_mag_r;
  logic             out_eol_r;
  logic             out_eof_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = rgbsob_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      rgbsob_pkg::REG_IMAGE_WIDTH:  prdata = rgbsob_pkg::PDATA_W'(image_width_r);
      rgbsob_pkg::REG_IMAGE_HEIGHT: prdata = rgbsob_pkg::PDATA_W'(image_height_r);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= rgbsob_pkg::WIDTH_W'(640);
      image_height_r <= rgbsob_pkg::HEIGHT_W'(480);
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgbsob_pkg::REG_IMAGE_WIDTH:  image_width_r  <= pwdata[rgbsob_pkg::WIDTH_W-1:0];
        rgbsob_pkg::REG_IMAGE_HEIGHT: image_height_r <= pwdata[rgbsob_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported frame size
  always_comb begin
    w_eff = CmpW'(image_width_r);
    if (w_eff < CmpW'(3)) w_eff = CmpW'(3);
    if (w_eff > CmpW'(rgbsob_pkg::MAX_WIDTH)) w_eff = CmpW'(rgbsob_pkg::MAX_WIDTH);
    h_eff = CmpW'(image_height_r);
    if (h_eff < CmpW'(3)) h_eff = CmpW'(3);
    if (h_eff > CmpW'(rgbsob_pkg::HEIGHT_LIMIT)) h_eff = CmpW'(rgbsob_pkg::HEIGHT_LIMIT);
  end

  // ---------------- input stage ----------------
  assign s1_adv        = s1_valid_r && (!s1_flags_r.produce || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign gray_sum = SumW'(in_chan.blue)  * SumW'(rgbsob_pkg::W_BLUE)
                  + SumW'(in_chan.green) * SumW'(rgbsob_pkg::W_GREEN)
                  + SumW'(in_chan.red)   * SumW'(rgbsob_pkg::W_RED);

  always_comb begin
    s0_flags.produce = (row_r >= RowW'(2)) && (col_r >= ColW'(2));
    s0_flags.eol     = (CmpW'(col_r) == w_eff - CmpW'(1));
    s0_flags.eof     = s0_flags.eol && (CmpW'(row_r) == h_eff - CmpW'(1));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (CmpW'(col_r) + CmpW'(1) >= w_eff) begin
        col_nxt = '0;
        if (CmpW'(row_r) + CmpW'(1) >= h_eff) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + RowW'(1);
        end
      end else begin
        col_nxt = col_r + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r  <= col_r;
      s1_gray_r  <= gray_sum[SumW-1:SumW-PixW];
      s1_flags_r <= s0_flags;
    end
  end

  // ---------------- line memory ----------------
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_addr_r] <= {mid_pix, s1_gray_r};
    end
    if (in_acc) begin
      rd_data_r <= line_mem[col_r];
    end
  end

  assign top_pix = rd_data_r[2*PixW-1:PixW];
  assign mid_pix = rd_data_r[PixW-1:0];

  // shift the window by one column
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_pix;
      win_r[4] <= mid_pix;
      win_r[5] <= s1_gray_r;
    end
  end

  // ---------------- sobel ----------------
  always_comb begin
    gx_pos = 10'(top_pix) + {1'b0, mid_pix, 1'b0} + 10'(s1_gray_r);
    gx_neg = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
    gy_pos = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(top_pix);
    gy_neg = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(s1_gray_r);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    mag    = 11'(gx_abs) + 11'(gy_abs);
    mag_sat = (mag > 11'd255) ? 8'hFF : mag[PixW-1:0];
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_flags_r.produce) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags_r.produce) begin
      out_mag_r <= mag_sat;
      out_eol_r <= s1_flags_r.eol;
      out_eof_r <= s1_flags_r.eof;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.edge_magnitude = out_mag_r;
  assign out_chan.end_of_line    = out_eol_r;
  assign out_chan.end_of_frame   = out_eof_r;

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CmpW'(col_r) < w_eff)
    else $error("column counter beyond line width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CmpW'(row_r) < h_eff)
    else $error("row counter beyond frame height");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_flags_r.produce) |=> out_valid_r)
    else $error("produced result not registered");

  a_eof_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_flags_r.eof |-> s1_flags_r.eol && s1_flags_r.produce)
    else $error("end of frame without end of line");
`endif

endmodule
`default_nettype wire

/* sim/tb_rgb_gray_sobel_edge_top.sv */
`timescale 1ns / 1ps
module tb_rgb_gray_sobel_edge_top;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 60;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_PIXELS = 540;
  localparam int unsigned CHUNK_LIMIT   = 120;
  localparam int unsigned DEFAULT_RUN   = 2 * 640 + 8;
  localparam int unsigned MAX_PRINTS    = 40;

  typedef struct packed {
    rgbsob_pkg::pix_t mag;
    logic eol;
    logic eof;
  } edge_result_t;

  class sobel_scoreboard;
    rgbsob_pkg::pix_t                line_mem [2*rgbsob_pkg::MAX_WIDTH];
    rgbsob_pkg::pix_t                window [6];
    int unsigned                     col_pos;
    int unsigned                     row_pos;
    logic [rgbsob_pkg::WIDTH_W-1:0]  width_reg;
    logic [rgbsob_pkg::HEIGHT_W-1:0] height_reg;
    edge_result_t                    pending [$];
    int unsigned                     errors;
    int unsigned                     results_checked;
    int unsigned                     line_ends;
    int unsigned                     frame_ends;
    int unsigned                     saturated;
    int unsigned                     reg_writes;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (window[i]) window[i] = '0;
      col_pos         = 0;
      row_pos         = 0;
      width_reg       = 12'd640;
      height_reg      = 13'd480;
      errors          = 0;
      results_checked = 0;
      line_ends       = 0;
      frame_ends      = 0;
      saturated       = 0;
      reg_writes      = 0;
    endfunction

    function int unsigned active_width();
      int unsigned v;
      v = width_reg;
      if (v < 3) v = 3;
      if (v > rgbsob_pkg::MAX_WIDTH) v = rgbsob_pkg::MAX_WIDTH;
      return v;
    endfunction

    function int unsigned active_height();
      int unsigned v;
      v = height_reg;
      if (v < 3) v = 3;
      if (v > rgbsob_pkg::HEIGHT_LIMIT) v = rgbsob_pkg::HEIGHT_LIMIT;
      return v;
    endfunction

    function int unsigned abs_gap(int unsigned a, int unsigned b);
      return (a >= b) ? a - b : b - a;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    function void write_reg(rgbsob_pkg::reg_idx_t idx,
                            logic [rgbsob_pkg::PDATA_W-1:0] value);
      if (idx == rgbsob_pkg::REG_IMAGE_WIDTH) width_reg = value[rgbsob_pkg::WIDTH_W-1:0];
      else height_reg = value[rgbsob_pkg::HEIGHT_W-1:0];
      col_pos = 0;
      row_pos = 0;
      reg_writes++;
    endfunction

    function void note_pixel(rgbsob_pkg::pix_t b, rgbsob_pkg::pix_t g, rgbsob_pkg::pix_t r);
      int unsigned  w;
      int unsigned  h;
      int unsigned  gray;
      int unsigned  top;
      int unsigned  mid;
      int unsigned  gx;
      int unsigned  gy;
      int unsigned  mag;
      edge_result_t want;
      w    = active_width();
      h    = active_height();
      gray = ((int'(rgbsob_pkg::W_BLUE) * b + int'(rgbsob_pkg::W_GREEN) * g
              + int'(rgbsob_pkg::W_RED) * r) >> 8) & 8'hFF;
      top  = line_mem[col_pos];
      mid  = line_mem[rgbsob_pkg::MAX_WIDTH + col_pos];
      line_mem[col_pos]                        = rgbsob_pkg::pix_t'(mid);
      line_mem[rgbsob_pkg::MAX_WIDTH + col_pos] = rgbsob_pkg::pix_t'(gray);
      if (row_pos >= 2 && col_pos >= 2) begin
        gx  = abs_gap(top + 2 * mid + gray, window[0] + 2 * window[1] + window[2]);
        gy  = abs_gap(window[0] + 2 * window[3] + top, window[2] + 2 * window[5] + gray);
        mag = gx + gy;
        if (mag > 255) mag = 255;
        want.mag = rgbsob_pkg::pix_t'(mag);
        want.eol = (col_pos == w - 1);
        want.eof = want.eol && (row_pos == h - 1);
        pending.push_back(want);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = rgbsob_pkg::pix_t'(top);
      window[4] = rgbsob_pkg::pix_t'(mid);
      window[5] = rgbsob_pkg::pix_t'(gray);
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    task check_result(edge_result_t got);
      edge_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with none expected", got.mag));
        return;
      end
      want = pending.pop_front();
      results_checked++;
      if (got.mag !== want.mag)
        report($sformatf("result %0d: edge_magnitude %0d, expected %0d",
                         results_checked, got.mag, want.mag));
      if (got.eol !== want.eol)
        report($sformatf("result %0d: end_of_line %b, expected %b",
                         results_checked, got.eol, want.eol));
      if (got.eof !== want.eof)
        report($sformatf("result %0d: end_of_frame %b, expected %b",
                         results_checked, got.eof, want.eof));
      if (want.eol) line_ends++;
      if (want.eof) frame_ends++;
      if (want.mag == 8'hFF) saturated++;
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [rgbsob_pkg::PADDR_W-1:0]  paddr;
  logic [rgbsob_pkg::PDATA_W-1:0]  pwdata;
  logic [rgbsob_pkg::PDATA_W-1:0]  prdata;
  logic                            pready;

  rgbsob_pix_if  pix_bus ();
  rgbsob_edge_if edge_bus ();

  rgb_gray_sobel_edge_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_bus.sink),
    .out_chan (edge_bus.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sobel_scoreboard sb = new();
  int unsigned     cycle_count;
  int unsigned     pixels_sent = 0;
  int unsigned     plan_total  = 1;
  int unsigned     idle_mode   = 0;
  bit              hold_done   = 1'b0;

  logic [23:0] directed_pix [20] = '{
    24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080, 24'h010101
  };

  int unsigned ext_w [7] = '{0, 1, 2, 3, 4095, 2, 4};
  int unsigned ext_h [7] = '{0, 2, 1, 3, 3, 8191, 4096};
  int unsigned ext_n [7] = '{18, 9, 9, 27, 24, 36, 10};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function int unsigned sender_idle_pct();
    case (idle_mode)
      0:       return 19;
      1:       return 52;
      default: return 0;
    endcase
  endfunction

  function int unsigned receiver_idle_pct();
    case (idle_mode)
      0:       return 52;
      1:       return 19;
      default: return 0;
    endcase
  endfunction

  task send_pixel(input rgbsob_pkg::pix_t b, input rgbsob_pkg::pix_t g,
                  input rgbsob_pkg::pix_t r);
    @(negedge clk);
    while ($urandom_range(1, 100) <= sender_idle_pct()) begin
      pix_bus.valid = 1'b0;
      @(negedge clk);
    end
    pix_bus.valid = 1'b1;
    pix_bus.blue  = b;
    pix_bus.green = g;
    pix_bus.red   = r;
    do @(posedge clk); while (!pix_bus.ready);
    sb.note_pixel(b, g, r);
    pixels_sent++;
    idle_mode = (pixels_sent * 3) / plan_total;
    if (idle_mode > 2) idle_mode = 2;
  endtask

  task release_pixels();
    @(negedge clk);
    pix_bus.valid = 1'b0;
  endtask

  function rgbsob_pkg::pix_t pick_channel(int unsigned style, rgbsob_pkg::pix_t base);
    int unsigned v;
    case (style)
      0: return rgbsob_pkg::pix_t'($urandom_range(0, 255));
      1: begin
        v = base + $urandom_range(0, 12);
        return (v > 255) ? 8'hFF : rgbsob_pkg::pix_t'(v);
      end
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task run_pixels(int unsigned count, int unsigned style);
    rgbsob_pkg::pix_t base;
    base = $urandom_range(0, 255);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) base = $urandom_range(0, 255);
      send_pixel(pick_channel(style, base), pick_channel(style, base),
                 pick_channel(style, base));
    end
    release_pixels();
  endtask

  task write_reg(rgbsob_pkg::reg_idx_t idx, logic [rgbsob_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task read_check(rgbsob_pkg::reg_idx_t idx);
    logic [rgbsob_pkg::PDATA_W-1:0] want;
    want = (idx == rgbsob_pkg::REG_IMAGE_WIDTH) ? rgbsob_pkg::PDATA_W'(sb.width_reg)
                                                : rgbsob_pkg::PDATA_W'(sb.height_reg);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report($sformatf("register %s read %0h, expected %0h", idx.name(), prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_frame(int unsigned w_val, int unsigned h_val, bit write_w, bit write_h);
    wait_drained();
    if (write_w) begin
      write_reg(rgbsob_pkg::REG_IMAGE_WIDTH, ($urandom & ~32'hFFF) | w_val);
      read_check(rgbsob_pkg::REG_IMAGE_WIDTH);
    end
    if (write_h) begin
      write_reg(rgbsob_pkg::REG_IMAGE_HEIGHT, ($urandom & ~32'h1FFF) | h_val);
      read_check(rgbsob_pkg::REG_IMAGE_HEIGHT);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.pending.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    edge_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sb.results_checked >= HOLD_AFTER) begin
        edge_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      edge_bus.ready = ($urandom_range(1, 100) > receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (rst_n && edge_bus.valid && edge_bus.ready)
      sb.check_result('{mag: edge_bus.edge_magnitude, eol: edge_bus.end_of_line,
                        eof: edge_bus.end_of_frame});
  end

  initial begin
    int unsigned random_sent;
    int unsigned pick;
    int unsigned which;
    int unsigned w_val;
    int unsigned h_val;
    int unsigned frame_px;
    int unsigned count;

    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pix_bus.valid = 1'b0;
    pix_bus.blue  = '0;
    pix_bus.green = '0;
    pix_bus.red   = '0;
    plan_total    = DEFAULT_RUN + 20 + RANDOM_PIXELS;
    foreach (ext_n[i]) plan_total += ext_n[i];

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    read_check(rgbsob_pkg::REG_IMAGE_WIDTH);
    read_check(rgbsob_pkg::REG_IMAGE_HEIGHT);
    run_pixels(DEFAULT_RUN, 0);

    set_frame(5, 4, 1'b1, 1'b1);
    foreach (directed_pix[i])
      send_pixel(directed_pix[i][23:16], directed_pix[i][15:8], directed_pix[i][7:0]);
    release_pixels();

    foreach (ext_w[i]) begin
      set_frame(ext_w[i], ext_h[i], 1'b1, 1'b1);
      run_pixels(ext_n[i], (ext_n[i] > 100) ? 0 : 2 - (i % 2));
    end

    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) w_val = $urandom_range(3, 24);
      else if (pick == 8) w_val = $urandom_range(0, 2);
      else w_val = $urandom_range(25, 130);
      pick = $urandom_range(0, 9);
      if (pick < 8) h_val = $urandom_range(3, 10);
      else if (pick == 8) h_val = $urandom_range(0, 2);
      else h_val = $urandom_range(11, 40);
      which = $urandom_range(0, 4);
      if (which != 0) set_frame(w_val, h_val, which != 2, which != 1);
      frame_px = sb.active_width() * sb.active_height();
      count = $urandom_range(0, 2) * frame_px + $urandom_range(1, frame_px);
      if (count > CHUNK_LIMIT) count = CHUNK_LIMIT;
      run_pixels(count, $urandom_range(0, 2));
      random_sent += count;
    end

    wait_drained();
    $display("Sent %0d pixels over %0d register writes; checked %0d edge results",
             pixels_sent, sb.reg_writes, sb.results_checked);
    $display("  with %0d line ends, %0d frame ends and %0d saturated magnitudes",
             sb.line_ends, sb.frame_ends, sb.saturated);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
